/* sv/slip_frame_decoder_assert.svh */
// ----------------------------------------------------------------------------
// slip_frame_decoder_assert.svh
// assertion macros for the slip frame decoder
// ----------------------------------------------------------------------------
`ifndef SLIP_FRAME_DECODER_ASSERT_SVH
`define SLIP_FRAME_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// checked on every rising edge outside reset
`define SFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// checked on every rising edge, reset included
`define SFD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`else

`define SFD_ASSERT(label, clk, rst_n, prop, msg)
`define SFD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* sv/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg
// types and codes shared by the slip frame decoder files
// ----------------------------------------------------------------------------
package sfd_pkg;

    // decoder mode codes
    localparam logic [1:0] MODE_IN_FRAME = 2'd0;
    localparam logic [1:0] MODE_ESCAPED  = 2'd1;
    localparam logic [1:0] MODE_UNSYNC   = 2'd2;

    // result kind codes
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_END_CODE            = 3'd0;
    localparam logic [2:0] CFG_ESCAPE_CODE         = 3'd1;
    localparam logic [2:0] CFG_ESCAPED_END_CODE    = 3'd2;
    localparam logic [2:0] CFG_ESCAPED_ESCAPE_CODE = 3'd3;
    localparam logic [2:0] CFG_START_IN_SYNC       = 3'd4;

    // configuration reset values
    localparam logic [7:0] END_CODE_RST            = 8'd192;
    localparam logic [7:0] ESCAPE_CODE_RST         = 8'd219;
    localparam logic [7:0] ESCAPED_END_CODE_RST    = 8'd220;
    localparam logic [7:0] ESCAPED_ESCAPE_CODE_RST = 8'd221;
    localparam logic       START_IN_SYNC_RST       = 1'b0;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] kind_t;

    typedef struct packed {
        kind_t kind;
        byte_t data_byte;
    } result_t;

endpackage

/* sv/sfd_rx_if.sv */
// ----------------------------------------------------------------------------
// sfd_rx_if
// received line byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface sfd_rx_if;

    logic          valid;
    logic          ready;
    sfd_pkg::byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

/* sv/sfd_res_if.sv */
// ----------------------------------------------------------------------------
// sfd_res_if
// decoded result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface sfd_res_if;

    logic           valid;
    logic           ready;
    sfd_pkg::kind_t kind;
    sfd_pkg::byte_t data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);

endinterface

/* sv/slip_frame_decoder.sv */
// ----------------------------------------------------------------------------
// slip_frame_decoder
// byte-serial slip frame decoder: unescapes payload bytes and reports
// frame ends and aborted frames
// ----------------------------------------------------------------------------
//
//  channel  dir  payload              transaction
//  -------  ---  -------------------  ------------------------------
//  rx       in   rx_byte[7:0]         one raw line byte
//  res      out  kind[1:0], data[7:0] data byte, frame end or abort
//  cfg      in   cfg_index, cfg_data  register write, no handshake
//
//  one byte accepted per cycle while rx.ready is high; the accepting edge
//  loads the input register, and the result register is loaded from it once
//  the result slot is free or drains.
//  the decoder mode register is the only loop in the decode logic.
//  a stalled result holds the result register; the input register then
//  fills and rx.ready drops only when both are occupied.
//  reset loads the default codes and puts the decoder out of sync.
//
`include "slip_frame_decoder_assert.svh"

module slip_frame_decoder (
    input  logic           clk,
    input  logic           rst_n,
    sfd_rx_if.sink         rx,
    sfd_res_if.source      res,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [7:0]     cfg_data
);

    // configuration
    sfd_pkg::byte_t end_code_reg;
    sfd_pkg::byte_t escape_code_reg;
    sfd_pkg::byte_t escaped_end_code_reg;
    sfd_pkg::byte_t escaped_escape_code_reg;

    // input register
    logic           in_valid_reg;
    sfd_pkg::byte_t in_byte_reg;

    // decoder mode
    logic [1:0]     mode_reg;
    logic [1:0]     mode_next;

    // result register
    logic             res_valid_reg;
    sfd_pkg::result_t res_reg;
    sfd_pkg::result_t res_next;
    logic             emit;

    logic advance;

    // the input register moves on when the result slot is free or drains
    assign advance  = in_valid_reg && (!res_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    always_comb
    begin
        mode_next          = mode_reg;
        emit               = 1'b0;
        res_next.kind      = sfd_pkg::KIND_DATA;
        res_next.data_byte = '0;

        if (in_byte_reg == end_code_reg)
        begin
            // end byte wins in every mode
            mode_next     = sfd_pkg::MODE_IN_FRAME;
            emit          = (mode_reg == sfd_pkg::MODE_IN_FRAME) ||
                            (mode_reg == sfd_pkg::MODE_ESCAPED);
            res_next.kind = sfd_pkg::KIND_END;
        end
        else
        begin
            case (mode_reg)
                sfd_pkg::MODE_ESCAPED:
                begin
                    emit = 1'b1;
                    if (in_byte_reg == escaped_end_code_reg)
                    begin
                        mode_next          = sfd_pkg::MODE_IN_FRAME;
                        res_next.data_byte = end_code_reg;
                    end
                    else if (in_byte_reg == escaped_escape_code_reg)
                    begin
                        mode_next          = sfd_pkg::MODE_IN_FRAME;
                        res_next.data_byte = escape_code_reg;
                    end
                    else
                    begin
                        mode_next     = sfd_pkg::MODE_UNSYNC;
                        res_next.kind = sfd_pkg::KIND_ABORT;
                    end
                end
                sfd_pkg::MODE_IN_FRAME:
                begin
                    if (in_byte_reg == escape_code_reg)
                    begin
                        mode_next = sfd_pkg::MODE_ESCAPED;
                    end
                    else
                    begin
                        emit               = 1'b1;
                        res_next.data_byte = in_byte_reg;
                    end
                end
                default:
                begin
                    // out of sync, and the unused code: drop the byte
                    mode_next = sfd_pkg::MODE_UNSYNC;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_code_reg            <= sfd_pkg::END_CODE_RST;
            escape_code_reg         <= sfd_pkg::ESCAPE_CODE_RST;
            escaped_end_code_reg    <= sfd_pkg::ESCAPED_END_CODE_RST;
            escaped_escape_code_reg <= sfd_pkg::ESCAPED_ESCAPE_CODE_RST;
            mode_reg                <= sfd_pkg::START_IN_SYNC_RST ? sfd_pkg::MODE_IN_FRAME
                                                                  : sfd_pkg::MODE_UNSYNC;
            in_valid_reg            <= 1'b0;
            res_valid_reg           <= 1'b0;
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end

            if (advance)
            begin
                mode_reg      <= mode_next;
                res_valid_reg <= emit;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    sfd_pkg::CFG_END_CODE:            end_code_reg <= cfg_data;
                    sfd_pkg::CFG_ESCAPE_CODE:         escape_code_reg <= cfg_data;
                    sfd_pkg::CFG_ESCAPED_END_CODE:    escaped_end_code_reg <= cfg_data;
                    sfd_pkg::CFG_ESCAPED_ESCAPE_CODE: escaped_escape_code_reg <= cfg_data;
                    sfd_pkg::CFG_START_IN_SYNC:
                    begin
                        mode_reg <= cfg_data[0] ? sfd_pkg::MODE_IN_FRAME
                                                : sfd_pkg::MODE_UNSYNC;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.kind      = res_reg.kind;
    assign res.data_byte = res_reg.data_byte;

    // an end byte leaves the decoder in frame absent a config write
    `SFD_ASSERT(a_end_resyncs, clk, rst_n,
        (advance && !cfg_we && in_byte_reg == end_code_reg)
            |=> (mode_reg == sfd_pkg::MODE_IN_FRAME),
        "end byte did not return decoder to in-frame mode")

    // an abort result drops sync absent a config write
    `SFD_ASSERT(a_abort_unsync, clk, rst_n,
        (advance && !cfg_we && emit && res_next.kind == sfd_pkg::KIND_ABORT)
            |=> (mode_reg == sfd_pkg::MODE_UNSYNC),
        "abort without loss of sync")

    // only data results carry a payload byte
    `SFD_ASSERT(a_ctrl_zero_data, clk, rst_n,
        (res_valid_reg && res_reg.kind != sfd_pkg::KIND_DATA)
            |-> (res_reg.data_byte == '0),
        "frame end or abort with nonzero data")

    // a stalled result keeps the queued byte in the input register
    `SFD_ASSERT(a_hold_queued, clk, rst_n,
        (in_valid_reg && res_valid_reg && !res.ready) |=> in_valid_reg,
        "queued byte lost while result stalled")

    // nothing is offered the cycle after a reset edge
    `SFD_ASSERT_ALWAYS(a_reset_empty, clk,
        !rst_n |=> (!res_valid_reg && !in_valid_reg),
        "pipeline not empty in reset")

endmodule

/* tb/sv/slip_frame_decoder_test.sv */
// ----------------------------------------------------------------------------
// slip_frame_decoder_test
// Self-checking bench for the slip frame decoder. A directed table covers
// delimiters, escapes, bad escapes and resync with the default codes. Random
// frames then run under several code settings, equal codes and extremes among
// them. Results are checked against fixed rows or a behavioral bench decoder.
// ----------------------------------------------------------------------------
module slip_frame_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        sfd_pkg::byte_t   rx;
        logic             known;
        logic             has_res;
        sfd_pkg::result_t res;
    } dir_row_t;

    localparam int               DIR_ROWS    = 21;
    localparam int               PHASES      = 8;
    localparam int               DRAIN_WAIT  = 6;
    localparam sfd_pkg::result_t NO_RESULT   = '0;
    localparam sfd_pkg::result_t FRAME_END   = {sfd_pkg::KIND_END, 8'h00};
    localparam sfd_pkg::result_t FRAME_ABORT = {sfd_pkg::KIND_ABORT, 8'h00};

    // default codes: end c0, escape db, escaped end dc, escaped escape dd
    dir_row_t dir_rows [DIR_ROWS] = '{
        {8'h41, 1'b1, 1'b0, NO_RESULT},          // out of sync, ignored
        {8'hc0, 1'b1, 1'b0, NO_RESULT},          // end restores sync silently
        {8'hc0, 1'b1, 1'b1, FRAME_END},          // empty frame
        {8'h00, 1'b1, 1'b1, sfd_pkg::KIND_DATA, 8'h00},
        {8'hff, 1'b1, 1'b1, sfd_pkg::KIND_DATA, 8'hff},
        {8'hdb, 1'b1, 1'b0, NO_RESULT},
        {8'hdc, 1'b1, 1'b1, sfd_pkg::KIND_DATA, 8'hc0},
        {8'hdb, 1'b1, 1'b0, NO_RESULT},
        {8'hdd, 1'b1, 1'b1, sfd_pkg::KIND_DATA, 8'hdb},
        {8'hdb, 1'b1, 1'b0, NO_RESULT},
        {8'hc0, 1'b1, 1'b1, FRAME_END},          // end wins over pending escape
        {8'hdb, 1'b1, 1'b0, NO_RESULT},
        {8'h55, 1'b1, 1'b1, FRAME_ABORT},        // bad escape
        {8'haa, 1'b1, 1'b0, NO_RESULT},
        {8'hdb, 1'b1, 1'b0, NO_RESULT},
        {8'hc0, 1'b1, 1'b0, NO_RESULT},
        {8'h12, 1'b0, 1'b0, NO_RESULT},
        {8'hdb, 1'b0, 1'b0, NO_RESULT},
        {8'hdb, 1'b0, 1'b0, NO_RESULT},          // escape after escape aborts
        {8'hc0, 1'b0, 1'b0, NO_RESULT},
        {8'hc0, 1'b1, 1'b1, FRAME_END}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    sfd_rx_if  rx_ch ();
    sfd_res_if res_ch ();

    slip_frame_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // decoder copy: codes and line mode
    sfd_pkg::byte_t   end_byte;
    sfd_pkg::byte_t   esc_byte;
    sfd_pkg::byte_t   esc_end_byte;
    sfd_pkg::byte_t   esc_esc_byte;
    logic [1:0]       line_mode;

    sfd_pkg::result_t expected_results [$];
    sfd_pkg::result_t oldest;
    int               mismatches = 0;
    logic             rx_steady  = 1'b0;
    logic             res_steady = 1'b0;

    function automatic logic decode_byte(input sfd_pkg::byte_t b,
                                         output sfd_pkg::result_t r);
        logic [1:0] prev;
        prev = line_mode;
        r = NO_RESULT;
        decode_byte = 1'b0;
        if (b == end_byte)
        begin
            line_mode = sfd_pkg::MODE_IN_FRAME;
            if (prev == sfd_pkg::MODE_IN_FRAME || prev == sfd_pkg::MODE_ESCAPED)
            begin
                r = FRAME_END;
                decode_byte = 1'b1;
            end
        end
        else if (prev == sfd_pkg::MODE_ESCAPED)
        begin
            decode_byte = 1'b1;
            if (b == esc_end_byte)
            begin
                line_mode = sfd_pkg::MODE_IN_FRAME;
                r = {sfd_pkg::KIND_DATA, end_byte};
            end
            else if (b == esc_esc_byte)
            begin
                line_mode = sfd_pkg::MODE_IN_FRAME;
                r = {sfd_pkg::KIND_DATA, esc_byte};
            end
            else
            begin
                line_mode = sfd_pkg::MODE_UNSYNC;
                r = FRAME_ABORT;
            end
        end
        else if (prev == sfd_pkg::MODE_IN_FRAME)
        begin
            if (b == esc_byte)
                line_mode = sfd_pkg::MODE_ESCAPED;
            else
            begin
                r = {sfd_pkg::KIND_DATA, b};
                decode_byte = 1'b1;
            end
        end
        else
            line_mode = sfd_pkg::MODE_UNSYNC;
    endfunction

    function automatic sfd_pkg::byte_t pick_byte();
        case ($urandom_range(0, 7))
            0:       pick_byte = end_byte;
            1:       pick_byte = esc_byte;
            2:       pick_byte = esc_end_byte;
            3:       pick_byte = esc_esc_byte;
            default: pick_byte = sfd_pkg::byte_t'($urandom);
        endcase
    endfunction

    // one rx transaction; a fixed expectation overrides the decoder copy
    task automatic send_byte(input sfd_pkg::byte_t b, input logic known,
                             input logic known_has, input sfd_pkg::result_t known_res);
        int               gap;
        logic             has;
        sfd_pkg::result_t r;
        gap = rx_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (rx_ch.ready !== 1'b1);
        has = decode_byte(b, r);
        if (known)
        begin
            has = known_has;
            r   = known_res;
        end
        if (has)
            expected_results.push_back(r);
    endtask

    task automatic write_reg(input logic [2:0] idx, input sfd_pkg::byte_t d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        case (idx)
            sfd_pkg::CFG_END_CODE:            end_byte     = d;
            sfd_pkg::CFG_ESCAPE_CODE:         esc_byte     = d;
            sfd_pkg::CFG_ESCAPED_END_CODE:    esc_end_byte = d;
            sfd_pkg::CFG_ESCAPED_ESCAPE_CODE: esc_esc_byte = d;
            sfd_pkg::CFG_START_IN_SYNC:
                line_mode = d[0] ? sfd_pkg::MODE_IN_FRAME : sfd_pkg::MODE_UNSYNC;
            default: ;
        endcase
    endtask

    // items with no result may still be in the pipe when the queue empties
    task automatic drain();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic send_frames(input int target);
        int             sent;
        int             n;
        int             roll;
        sfd_pkg::byte_t v;
        sent = 0;
        while (sent < target)
        begin
            n = $urandom_range(0, 12);
            repeat (n)
            begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                begin
                    send_byte(pick_byte(), 1'b0, 1'b0, NO_RESULT);
                    sent++;
                end
                else if (roll == 1)
                begin
                    // escape followed by anything, mostly a bad escape
                    send_byte(esc_byte, 1'b0, 1'b0, NO_RESULT);
                    send_byte(pick_byte(), 1'b0, 1'b0, NO_RESULT);
                    sent += 2;
                end
                else
                begin
                    v = pick_byte();
                    if (v == end_byte || v == esc_byte)
                    begin
                        send_byte(esc_byte, 1'b0, 1'b0, NO_RESULT);
                        send_byte(v == end_byte ? esc_end_byte : esc_esc_byte,
                                  1'b0, 1'b0, NO_RESULT);
                        sent += 2;
                    end
                    else
                    begin
                        send_byte(v, 1'b0, 1'b0, NO_RESULT);
                        sent++;
                    end
                end
            end
            send_byte(end_byte, 1'b0, 1'b0, NO_RESULT);
            sent++;
        end
    endtask

    // result sink with random stalls, or none while res_steady is set
    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            gap = res_steady ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (res_ch.valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got kind %0d data %02h",
                         $time, res_ch.kind, res_ch.data_byte);
                mismatches++;
            end
            else
            begin
                oldest = expected_results.pop_front();
                if (res_ch.kind !== oldest.kind || res_ch.data_byte !== oldest.data_byte)
                begin
                    $display({"%0t: result mismatch, expected kind %0d data %02h,",
                              " got kind %0d data %02h"},
                             $time, oldest.kind, oldest.data_byte,
                             res_ch.kind, res_ch.data_byte);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        sfd_pkg::byte_t set_end;
        sfd_pkg::byte_t set_esc;
        sfd_pkg::byte_t set_esc_end;
        sfd_pkg::byte_t set_esc_esc;
        logic           set_sync;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        end_byte      = sfd_pkg::END_CODE_RST;
        esc_byte      = sfd_pkg::ESCAPE_CODE_RST;
        esc_end_byte  = sfd_pkg::ESCAPED_END_CODE_RST;
        esc_esc_byte  = sfd_pkg::ESCAPED_ESCAPE_CODE_RST;
        line_mode     = sfd_pkg::START_IN_SYNC_RST ? sfd_pkg::MODE_IN_FRAME
                                                   : sfd_pkg::MODE_UNSYNC;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].rx, dir_rows[i].known, dir_rows[i].has_res,
                      dir_rows[i].res);
        rx_ch.valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0:       {set_end, set_esc, set_esc_end, set_esc_esc, set_sync} =
                             {8'h00, 8'hff, 8'h00, 8'hff, 1'b1};
                1:       {set_end, set_esc, set_esc_end, set_esc_esc, set_sync} =
                             {8'hff, 8'h00, 8'h01, 8'h01, 1'b0};
                2:       {set_end, set_esc, set_esc_end, set_esc_esc, set_sync} =
                             {8'h7e, 8'h7e, 8'h5e, 8'h5d, 1'b1};
                3:       {set_end, set_esc, set_esc_end, set_esc_esc, set_sync} =
                             {sfd_pkg::END_CODE_RST, sfd_pkg::ESCAPE_CODE_RST,
                              sfd_pkg::ESCAPED_END_CODE_RST,
                              sfd_pkg::ESCAPED_ESCAPE_CODE_RST, 1'b0};
                default: {set_end, set_esc, set_esc_end, set_esc_esc, set_sync} =
                             {sfd_pkg::byte_t'($urandom), sfd_pkg::byte_t'($urandom),
                              sfd_pkg::byte_t'($urandom), sfd_pkg::byte_t'($urandom),
                              1'($urandom)};
            endcase
            write_reg(sfd_pkg::CFG_END_CODE, set_end);
            write_reg(sfd_pkg::CFG_ESCAPE_CODE, set_esc);
            write_reg(sfd_pkg::CFG_ESCAPED_END_CODE, set_esc_end);
            write_reg(sfd_pkg::CFG_ESCAPED_ESCAPE_CODE, set_esc_esc);
            write_reg(sfd_pkg::CFG_START_IN_SYNC, {7'($urandom), set_sync});
            // indexes past the last register must be ignored
            write_reg(3'($urandom_range(5, 7)), sfd_pkg::byte_t'($urandom));
            cfg_we <= 1'b0;

            rx_steady  = ($urandom_range(0, 3) == 0);
            res_steady = ($urandom_range(0, 3) == 0);
            send_frames($urandom_range(75, 88));
            rx_ch.valid <= 1'b0;
        end

        drain();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
